[rtl/rabb_pkg.sv]
// shared constants and channel blend function for the rotated alpha blend blitter
`default_nettype none

package rabb_pkg;

    // field widths
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int COV_W   = 8;
    localparam int RGB_W   = 24;
    localparam int IDX_W   = 19;
    localparam int ORG_W   = 11;
    localparam int CFG_IDX_W = 2;

    // packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR = 2'd0,
        CFG_ORIGIN_X = 2'd1,
        CFG_ORIGIN_Y = 2'd2
    } cfg_index_t;

    localparam logic [RGB_W-1:0] FG_COLOR_RESET = 24'hF4F4F8;

    // d + (f - d) * a / 255, quotient truncated toward zero
    // the magnitude is divided by 255 as (p + (p >> 8) + 1) >> 8, exact for p <= 65025
    function automatic logic [7:0] mix_channel(
        input logic [7:0] f,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic        up;
        logic [7:0]  diff;
        logic [15:0] prod;
        logic [16:0] sum;
        logic [7:0]  q;
        up   = (f >= d);
        diff = up ? (f - d) : (d - f);
        prod = 16'(diff) * 16'(a);
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        q    = sum[15:8];
        return up ? (d + q) : (d - q);
    endfunction

endpackage

`default_nettype wire

[rtl/rotated_alpha_blend_blit.sv]
// rotated alpha blend blitter: clip, rotate and blend one coverage sample per word
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------------
//  s_      | in        | tdata: glyph_col, glyph_row, coverage, dest_pixel
//  m_      | out       | tdata: pixel_index, new_pixel; tuser: write_enable
//  cfg_    | in        | cfg_index, cfg_data (fg_color, origin_x, origin_y)
//
//  one word per clock sustained while m_tready stays high; an accepted word passes through
//  the input register and then the output register before it shows on m_tvalid
//  stages: input register, then index multiply and blend into the output register
//  aresetn is synchronous, active low; it empties both stages and restores the config
//  an output stall holds the output register; the input register still loads while
//  it is empty or moving forward, so s_tready drops only when both stages are full
`default_nettype none

module rotated_alpha_blend_blit #(
    parameter int PANEL_WIDTH  = 480,
    parameter int PANEL_HEIGHT = 800,
    parameter int SCAN_PITCH   = 800
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [9:0] glyph_col, [19:10] glyph_row, [27:20] coverage, [51:28] dest_pixel
    input  wire logic [rabb_pkg::S_DATA_W-1:0]  s_tdata,
    // result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [18:0] pixel_index, [42:19] new_pixel
    output logic [rabb_pkg::M_DATA_W-1:0]       m_tdata,
    // [0] write_enable
    output logic                                m_tuser,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rabb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rabb_pkg::RGB_W-1:0]     cfg_data
);
    import rabb_pkg::*;

    localparam int POS_W = 14;
    localparam int ROT_W = 12;
    localparam int PIT_W = 13;
    localparam int SUM_W = ROT_W + PIT_W + 1;

    localparam logic signed [POS_W-1:0] PW_S = POS_W'(PANEL_WIDTH);
    localparam logic signed [POS_W-1:0] PH_S = POS_W'(PANEL_HEIGHT);
    localparam logic [PIT_W-1:0]        PITCH = PIT_W'(SCAN_PITCH);

    // configuration registers
    logic [RGB_W-1:0] fg_color_reg;
    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;

    // input stage
    logic             in_valid_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COV_W-1:0] in_cov_reg;
    logic [RGB_W-1:0] in_dest_reg;

    // output stage
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [RGB_W-1:0] out_pix_reg;
    logic             out_we_reg;

    logic             advance;
    logic             load_in;

    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    in_panel;
    logic [POS_W-1:0]        rot_x_full;
    logic [ROT_W-1:0]        rot_x;
    logic [SUM_W-1:0]        idx_full;
    logic [7:0]              red_mix;
    logic [7:0]              grn_mix;
    logic [7:0]              blu_mix;
    logic                    we_next;
    logic [IDX_W-1:0]        idx_next;
    logic [RGB_W-1:0]        pix_next;

    // handshake flow
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign load_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg <= FG_COLOR_RESET;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FG_COLOR: fg_color_reg <= cfg_data;
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[ORG_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_col_reg  <= s_tdata[9:0];
            in_row_reg  <= s_tdata[19:10];
            in_cov_reg  <= s_tdata[27:20];
            in_dest_reg <= s_tdata[51:28];
        end
    end

    // portrait position and clip test
    always_comb begin
        pos_x    = POS_W'($signed(origin_x_reg)) + $signed({4'b0, in_col_reg});
        pos_y    = POS_W'($signed(origin_y_reg)) + $signed({4'b0, in_row_reg});
        in_panel = !pos_x[POS_W-1] && (pos_x < PW_S) && !pos_y[POS_W-1] && (pos_y < PH_S);
    end

    // counter-clockwise rotation into the scan buffer
    always_comb begin
        rot_x_full = POS_W'(PW_S - 14'sd1 - pos_x);
        rot_x      = rot_x_full[ROT_W-1:0];
        idx_full   = SUM_W'(rot_x) * SUM_W'(PITCH) + SUM_W'(pos_y[ROT_W-1:0]);
    end

    // per channel blend
    always_comb begin
        red_mix  = mix_channel(fg_color_reg[23:16], in_dest_reg[23:16], in_cov_reg);
        grn_mix  = mix_channel(fg_color_reg[15:8],  in_dest_reg[15:8],  in_cov_reg);
        blu_mix  = mix_channel(fg_color_reg[7:0],   in_dest_reg[7:0],   in_cov_reg);
        we_next  = in_panel && (in_cov_reg != '0);
        idx_next = in_panel ? idx_full[IDX_W-1:0] : '0;
        pix_next = we_next ? {red_mix, grn_mix, blu_mix} : in_dest_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_idx_reg <= idx_next;
            out_pix_reg <= pix_next;
            out_we_reg  <= we_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_pix_reg, out_idx_reg};
    assign m_tuser  = out_we_reg;

    // a word in the input stage moves to the output stage when it advances
    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg) |=> out_valid_reg)
        else $error("input word lost between stages");

    // write enable only for nonzero coverage
    a_we_cov: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg) |=> (!out_we_reg || $past(in_cov_reg != '0)))
        else $error("write enabled for zero coverage");

    // an empty input stage always takes a word
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while input stage empty");

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_pix_reg)
                                          && $stable(out_idx_reg)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire
